### hdl/skvt_pkg.sv
// ----------------------------------------------------------------------------
// skvt_pkg
// Shared types and constants for the sorted key/value table.
// ----------------------------------------------------------------------------
package skvt_pkg;

  localparam int unsigned CapacityDef  = 256;
  localparam int unsigned KeyBitsDef   = 32;
  localparam int unsigned ValueBitsDef = 32;

  localparam int unsigned ActionW = 3;
  localparam int unsigned StatusW = 3;

  typedef enum logic [ActionW-1:0] {
    ACT_ADD         = 3'd0,
    ACT_FIND        = 3'd1,
    ACT_FIND_OR_ADD = 3'd2,
    ACT_REMOVE_KEY  = 3'd3,
    ACT_REMOVE_POS  = 3'd4,
    ACT_REPLACE     = 3'd5,
    ACT_GET_POS     = 3'd6,
    ACT_SET_POS     = 3'd7
  } action_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK         = 3'd0,
    ST_NOT_FOUND  = 3'd1,
    ST_PRESENT    = 3'd2,
    ST_FULL       = 3'd3,
    ST_BAD_POS    = 3'd4
  } status_e;

endpackage

### hdl/skvt_ram.sv
// ----------------------------------------------------------------------------
// skvt_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module skvt_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hdl/sorted_key_value_table_top.sv
// ----------------------------------------------------------------------------
// sorted_key_value_table_top
// Sorted key/value table with binary-search lookup and shifting insert/remove.
// ----------------------------------------------------------------------------
//
//   Channel  | Handshake          | Fields
//   ---------+--------------------+------------------------------------------
//   command  | start_i & !busy_o  | action, key, value, position, allow_add
//   result   | done_o (one cycle) | status, found, added, slot, key_out,
//            |                    | value_out, entry_count
//
// One beat on the command channel gives exactly one result beat. A binary
// search issues a key read and then compares the probed key, for at most
// log2(CAPACITY)+1 probes, then reads the value at the slot.
// An insert or remove then moves each entry after the position one slot,
// reading and then writing it through the single key and value RAM ports.
// The done state follows, and the result beat comes in the cycle after it.
// Reset clears the live count, state and done flag, not the table contents.
// The receiver cannot stall: the result is shown for one cycle with done_o.
//
module sorted_key_value_table_top
  import skvt_pkg::*;
#(
  parameter int unsigned CAPACITY   = CapacityDef,
  parameter int unsigned KEY_BITS   = KeyBitsDef,
  parameter int unsigned VALUE_BITS = ValueBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  action_i,
  input  logic [31:0] key_i,
  input  logic [31:0] value_i,
  input  logic [7:0]  position_i,
  input  logic        allow_add_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic        found_o,
  output logic        added_o,
  output logic [8:0]  slot_o,
  output logic [31:0] key_out_o,
  output logic [31:0] value_out_o,
  output logic [8:0]  entry_count_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  // Counts run to CAPACITY itself, so one bit more than the address.
  localparam int unsigned CW = AW + 1;
  // Search bounds are signed and may step one below zero.
  localparam int unsigned SW = CW + 2;
  localparam int unsigned KW = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int unsigned VW = (VALUE_BITS < 32) ? VALUE_BITS : 32;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_PROBE = 10'b0000000010,  // issue a search read
    S_CMP   = 10'b0000000100,  // compare the probed key
    S_VREAD = 10'b0000001000,  // issue a value read at the slot
    S_VGET  = 10'b0000010000,  // capture the value, decide the action
    S_SHR   = 10'b0000100000,  // read an entry to move
    S_SHW   = 10'b0001000000,  // write the moved entry
    S_FIN   = 10'b0010000000,  // final write at the slot
    S_DONE  = 10'b0100000000,
    S_KGET  = 10'b1000000000   // positional: key and value captured
  } state_e;

  state_e state_q, state_d;

  logic [2:0]          act_q;
  logic [KW-1:0]       key_q;
  logic [VW-1:0]       val_q;
  logic                allow_q;
  logic [CW-1:0]       count_q, count_d;
  logic signed [CW+1:0] lo_q, hi_q, mid_q;
  logic                hit_q;
  logic [CW-1:0]       slot_q;
  logic [CW-1:0]       idx_q;       // shift cursor
  logic                ins_q;       // shift direction: 1 insert, 0 remove
  logic [2:0]          st_q;
  logic                added_q;
  logic [KW-1:0]       kout_q;
  logic [VW-1:0]       vout_q;
  logic                done_q;

  logic          k_we, v_we;
  logic [AW-1:0] k_wa, v_wa, raddr;
  logic [KW-1:0] k_wd, k_rd;
  logic [VW-1:0] v_wd, v_rd;

  skvt_ram #(.Width(KW), .Depth(CAPACITY)) u_keys (
    .clk_i, .we_i(k_we), .waddr_i(k_wa), .wdata_i(k_wd), .raddr_i(raddr),
    .rdata_o(k_rd)
  );
  skvt_ram #(.Width(VW), .Depth(CAPACITY)) u_vals (
    .clk_i, .we_i(v_we), .waddr_i(v_wa), .wdata_i(v_wd), .raddr_i(raddr),
    .rdata_o(v_rd)
  );

  logic eq_c, gt_c;
  assign eq_c  = (k_rd == key_q);
  assign gt_c  = (k_rd > key_q);

  // Read address: search probe, slot, or shift source.
  always_comb begin
    raddr = slot_q[AW-1:0];
    if (state_q == S_PROBE) begin
      raddr = mid_q[AW-1:0];
    end else if (state_q == S_SHR) begin
      raddr = ins_q ? AW'(idx_q - CW'(1)) : AW'(idx_q + CW'(1));
    end
  end

  always_comb begin
    k_we = 1'b0;
    v_we = 1'b0;
    k_wa = idx_q[AW-1:0];
    v_wa = idx_q[AW-1:0];
    k_wd = k_rd;
    v_wd = v_rd;
    if (state_q == S_SHW) begin
      k_we = 1'b1;
      v_we = 1'b1;
    end else if (state_q == S_FIN) begin
      k_wa = slot_q[AW-1:0];
      v_wa = slot_q[AW-1:0];
      k_wd = key_q;
      v_wd = val_q;
      k_we = (act_q != ACT_REPLACE) || !hit_q;
      v_we = 1'b1;
    end
  end

  // An insert moves down to the slot; a remove moves up to the new count,
  // which is already in place while the shift runs.
  logic is_ins, is_rem;
  logic [CW-1:0] shift_end;
  assign shift_end = ins_q ? slot_q : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= (state_q == S_DONE);
    end
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    is_ins  = 1'b0;
    is_rem  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          unique case (action_i)
            ACT_REMOVE_POS, ACT_GET_POS, ACT_SET_POS: begin
              state_d = ({1'b0, position_i} >= 9'(count_q)) ? S_DONE : S_VREAD;
            end
            default: begin
              state_d = (count_q == '0) ? S_VGET : S_PROBE;
            end
          endcase
        end
      end
      S_PROBE: state_d = S_CMP;
      S_CMP: begin
        if (eq_c || !(hi_q > lo_q)) state_d = S_VREAD;
        else state_d = S_PROBE;
      end
      S_VREAD: state_d = (act_q == ACT_GET_POS || act_q == ACT_REMOVE_POS ||
                          act_q == ACT_SET_POS) ? S_KGET : S_VGET;
      S_KGET: begin
        if (act_q == ACT_REMOVE_POS) begin
          state_d = (slot_q == CW'(count_q - CW'(1))) ? S_DONE : S_SHR;
          count_d = CW'(count_q - CW'(1));
        end else if (act_q == ACT_SET_POS) begin
          state_d = S_FIN;
        end else begin
          state_d = S_DONE;
        end
      end
      S_VGET: begin
        priority case (1'b1)
          hit_q && (act_q == ACT_REMOVE_KEY): is_rem = 1'b1;
          hit_q && (act_q == ACT_REPLACE): state_d = S_FIN;
          hit_q: state_d = S_DONE;
          (act_q == ACT_ADD) || (act_q == ACT_FIND_OR_ADD) ||
          ((act_q == ACT_REPLACE) && allow_q): begin
            if (count_q == CW'(CAPACITY)) state_d = S_DONE;
            else is_ins = 1'b1;
          end
          default: state_d = S_DONE;
        endcase
        if (is_rem) begin
          state_d = (slot_q == CW'(count_q - CW'(1))) ? S_DONE : S_SHR;
          count_d = CW'(count_q - CW'(1));
        end
        if (is_ins) begin
          state_d = (slot_q == count_q) ? S_FIN : S_SHR;
          count_d = CW'(count_q + CW'(1));
        end
      end
      S_SHR: state_d = S_SHW;
      S_SHW: begin
        if (ins_q) state_d = (CW'(idx_q - CW'(1)) == shift_end) ? S_FIN : S_SHR;
        else state_d = (CW'(idx_q + CW'(1)) == shift_end) ? S_DONE : S_SHR;
      end
      S_FIN: state_d = S_DONE;
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        act_q   <= action_i;
        key_q   <= key_i[KW-1:0];
        val_q   <= value_i[VW-1:0];
        allow_q <= allow_add_i;
        lo_q    <= '0;
        hi_q    <= SW'($signed({2'b0, count_q}) - 1);
        hit_q   <= 1'b0;
        added_q <= 1'b0;
        kout_q  <= '0;
        vout_q  <= '0;
        if (action_i == ACT_REMOVE_POS || action_i == ACT_GET_POS ||
            action_i == ACT_SET_POS) begin
          st_q   <= ({1'b0, position_i} >= 9'(count_q)) ? ST_BAD_POS : ST_OK;
          slot_q <= CW'(position_i);
          mid_q  <= '0;
        end else begin
          st_q   <= ST_OK;
          slot_q <= '0;
          mid_q  <= SW'(($signed({2'b0, count_q}) - 1) >>> 1);
        end
      end
      S_CMP: begin
        if (eq_c) begin
          hit_q  <= 1'b1;
          slot_q <= CW'(mid_q);
        end else if (!(hi_q > lo_q)) begin
          slot_q <= gt_c ? CW'(mid_q) : CW'(mid_q + 1);
        end else begin
          if (gt_c) begin
            // When the upper bound drops below the lower one, the last
            // probe goes to the lower bound.
            hi_q  <= SW'(mid_q - 1);
            mid_q <= (mid_q > lo_q) ? SW'(lo_q + (((mid_q - 1) - lo_q) >>> 1))
                                    : lo_q;
          end else begin
            lo_q  <= SW'(mid_q + 1);
            mid_q <= SW'((mid_q + 1) + ((hi_q - (mid_q + 1)) >>> 1));
          end
        end
      end
      S_KGET: begin
        kout_q <= (act_q == ACT_SET_POS) ? '0 : k_rd;
        vout_q <= v_rd;
        ins_q  <= 1'b0;
        idx_q  <= slot_q;
      end
      S_VGET: begin
        idx_q <= is_rem ? slot_q : count_q;
        ins_q <= is_ins;
        if (hit_q) begin
          vout_q <= (act_q == ACT_ADD) ? '0 : v_rd;
          if (act_q == ACT_ADD) st_q <= ST_PRESENT;
        end else begin
          if (act_q == ACT_FIND_OR_ADD) vout_q <= val_q;
          if (is_ins) added_q <= 1'b1;
          else if (act_q == ACT_FIND || act_q == ACT_REMOVE_KEY ||
                   act_q == ACT_REPLACE && !allow_q) st_q <= ST_NOT_FOUND;
          else st_q <= ST_FULL;
        end
      end
      S_SHW: idx_q <= ins_q ? CW'(idx_q - CW'(1)) : CW'(idx_q + CW'(1));
      default: ;
    endcase
  end

  assign busy_o        = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign status_o      = st_q;
  assign found_o       = hit_q;
  assign added_o       = added_q;
  assign slot_o        = 9'(slot_q);
  assign key_out_o     = 32'(kout_q);
  assign value_out_o   = 32'(vout_q);
  assign entry_count_o = 9'(count_q);

  // Result beats only follow a finished command, and the count moves by one.
  a_done_after_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == S_DONE)) else $error("stray result beat");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      (count_q == $past(count_q) + 1 || count_q + 1 == $past(count_q)))
    else $error("count jumped");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY)) else $error("count past capacity");
  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !(k_we || v_we)) else $error("write while idle");

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sorted key/value table: commands go in through
// the start/busy handshake, each result is checked against a behavioral
// predictor of the table that runs on every accepted command beat.
// ----------------------------------------------------------------------------
module tb;
  import skvt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth      = 256;
  localparam int unsigned CycleLimit = 3_000_000;
  localparam int unsigned TailCycles = 600;

  // One command beat as the driver presents it. A set drain flag holds the
  // beat back until every outstanding result has come back.
  typedef struct {
    action_e     act;
    logic [31:0] key;
    logic [31:0] value;
    logic [7:0]  pos;
    logic        allow;
    bit          drain;
  } command_t;

  // One result beat as the table should produce it.
  typedef struct {
    status_e     st;
    logic        found;
    logic        added;
    logic [8:0]  slot;
    logic [31:0] key_out;
    logic [31:0] value_out;
    logic [8:0]  count;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic [2:0] action_i = '0;
  logic [31:0] key_i = '0;
  logic [31:0] value_i = '0;
  logic [7:0] position_i = '0;
  logic allow_add_i = 1'b0;
  logic busy_o, done_o, found_o, added_o;
  logic [2:0] status_o;
  logic [8:0] slot_o, entry_count_o;
  logic [31:0] key_out_o, value_out_o;

  sorted_key_value_table_top uut (
    .clk_i, .rst_ni, .start_i, .busy_o, .action_i, .key_i, .value_i,
    .position_i, .allow_add_i, .done_o, .status_o, .found_o, .added_o,
    .slot_o, .key_out_o, .value_out_o, .entry_count_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predictor state: a private copy of the table.
  logic [31:0] shadow_keys [Depth];
  logic [31:0] shadow_values [Depth];
  int unsigned shadow_count = 0;

  command_t pending_cmds[$];
  outcome_t awaited_results[$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned beats_sent = 0;
  int unsigned cycles = 0;
  int unsigned full_hits = 0;
  bit beat_taken = 0;

  // Binary search over the live entries, following the exact probe order so
  // that the prediction stays right after a raw write breaks the ordering.
  function automatic bit locate(input logic [31:0] k, output int unsigned p);
    int lo, hi, mid;
    logic [31:0] probe;
    if (shadow_count == 0) begin
      p = 0;
      return 0;
    end
    lo = 0;
    hi = shadow_count - 1;
    while (hi > lo) begin
      mid = lo + (hi - lo) / 2;
      probe = shadow_keys[mid];
      if (probe == k) begin
        p = mid;
        return 1;
      end
      if (probe > k) hi = mid - 1;
      else lo = mid + 1;
    end
    probe = shadow_keys[lo];
    if (probe == k) begin
      p = lo;
      return 1;
    end
    p = (probe > k) ? lo : lo + 1;
    return 0;
  endfunction

  function automatic bit shift_in(input int unsigned p, input logic [31:0] k,
                                  input logic [31:0] v);
    if (shadow_count >= Depth) return 0;
    for (int i = shadow_count; i > p; i--) begin
      shadow_keys[i] = shadow_keys[i-1];
      shadow_values[i] = shadow_values[i-1];
    end
    shadow_keys[p] = k;
    shadow_values[p] = v;
    shadow_count++;
    return 1;
  endfunction

  function automatic void shift_out(input int unsigned p);
    for (int i = p; i + 1 < shadow_count; i++) begin
      shadow_keys[i] = shadow_keys[i+1];
      shadow_values[i] = shadow_values[i+1];
    end
    shadow_count--;
  endfunction

  // Applies one command to the private table and returns the result beat.
  function automatic outcome_t apply_command(input command_t c);
    outcome_t r;
    int unsigned p;
    bit hit;
    r = '{st: ST_OK, found: 0, added: 0, slot: '0, key_out: '0,
          value_out: '0, count: '0};
    if (c.act inside {ACT_REMOVE_POS, ACT_GET_POS, ACT_SET_POS}) begin
      r.slot = {1'b0, c.pos};
      if (c.pos >= shadow_count) begin
        r.st = ST_BAD_POS;
      end else begin
        r.value_out = shadow_values[c.pos];
        if (c.act != ACT_SET_POS) r.key_out = shadow_keys[c.pos];
        if (c.act == ACT_REMOVE_POS) begin
          shift_out(c.pos);
        end else if (c.act == ACT_SET_POS) begin
          shadow_keys[c.pos] = c.key;
          shadow_values[c.pos] = c.value;
        end
      end
    end else begin
      hit = locate(c.key, p);
      r.found = hit;
      r.slot = 9'(p);
      case (c.act)
        ACT_ADD: begin
          if (hit) r.st = ST_PRESENT;
          else if (shift_in(p, c.key, c.value)) r.added = 1;
          else r.st = ST_FULL;
        end
        ACT_FIND: begin
          if (hit) r.value_out = shadow_values[p];
          else r.st = ST_NOT_FOUND;
        end
        ACT_FIND_OR_ADD: begin
          if (hit) begin
            r.value_out = shadow_values[p];
          end else begin
            r.value_out = c.value;
            if (shift_in(p, c.key, c.value)) r.added = 1;
            else r.st = ST_FULL;
          end
        end
        ACT_REMOVE_KEY: begin
          if (hit) begin
            r.value_out = shadow_values[p];
            shift_out(p);
          end else begin
            r.st = ST_NOT_FOUND;
          end
        end
        default: begin
          if (hit) begin
            r.value_out = shadow_values[p];
            shadow_values[p] = c.value;
          end else if (!c.allow) begin
            r.st = ST_NOT_FOUND;
          end else if (shift_in(p, c.key, c.value)) begin
            r.added = 1;
          end else begin
            r.st = ST_FULL;
          end
        end
      endcase
    end
    if (r.st == ST_FULL) full_hits++;
    r.count = 9'(shadow_count);
    return r;
  endfunction

  // Driver. Inputs move on the falling edge. A beat stays up until the
  // rising edge that accepts it; then the next one follows after a random
  // gap, or back to back while a no-gap burst is running.
  int unsigned gap = 0;
  int unsigned burst_left = 0;
  always @(negedge clk_i) begin
    if (rst_ni && !(start_i && !beat_taken)) begin
      beat_taken = 0;
      if (gap > 0) begin
        gap--;
        start_i <= 1'b0;
      end else if (pending_cmds.size() > 0 &&
                   !(pending_cmds[0].drain && awaited_results.size() > 0)) begin
        command_t c;
        c = pending_cmds.pop_front();
        action_i <= c.act;
        key_i <= c.key;
        value_i <= c.value;
        position_i <= c.pos;
        allow_add_i <= c.allow;
        start_i <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
          gap = 0;
        end else begin
          gap = $urandom_range(0, 9);
          if ($urandom_range(0, 19) == 0) burst_left = $urandom_range(10, 40);
        end
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor. On each rising edge it checks a result beat first, then runs
  // the predictor for a command beat the table just accepted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("tb: result beat with nothing pending");
        end else begin
          outcome_t e;
          e = awaited_results.pop_front();
          if (status_o !== e.st || found_o !== e.found || added_o !== e.added ||
              slot_o !== e.slot || key_out_o !== e.key_out ||
              value_out_o !== e.value_out || entry_count_o !== e.count) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"tb: mismatch at result %0d: exp st=%0d f=%0b a=%0b ",
                        "slot=%0d k=%h v=%h n=%0d / got st=%0d f=%0b a=%0b ",
                        "slot=%0d k=%h v=%h n=%0d"},
                       results_seen, e.st, e.found, e.added, e.slot,
                       e.key_out, e.value_out, e.count, status_o, found_o,
                       added_o, slot_o, key_out_o, value_out_o, entry_count_o);
          end
        end
      end
      if (start_i && !busy_o) begin
        command_t c;
        c.act = action_e'(action_i);
        c.key = key_i;
        c.value = value_i;
        c.pos = position_i;
        c.allow = allow_add_i;
        c.drain = 0;
        awaited_results.push_back(apply_command(c));
        beats_sent++;
        beat_taken = 1;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: errors");
      $finish;
    end
  end

  // A small pool of keys makes hits, duplicates and removals common.
  logic [31:0] key_pool [48];

  function automatic void queue_cmd(input action_e a, input logic [31:0] k,
                                    input logic [31:0] v, input logic [7:0] p,
                                    input logic al, input bit dr = 0);
    command_t c;
    c = '{act: a, key: k, value: v, pos: p, allow: al, drain: dr};
    pending_cmds.push_back(c);
  endfunction

  function automatic void queue_random_cmd();
    logic [31:0] k;
    logic [7:0] p;
    if ($urandom_range(0, 9) < 7) k = key_pool[$urandom_range(0, 47)];
    else k = $urandom;
    if ($urandom_range(0, 9) < 6) p = 8'($urandom_range(0, 40));
    else p = 8'($urandom_range(0, 255));
    queue_cmd(action_e'($urandom_range(0, 7)), k, $urandom, p,
              1'($urandom_range(0, 1)));
  endfunction

  initial begin
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 48; i++) key_pool[i] = $urandom;

    // Directed part on an empty, then small table: every action, both key
    // extremes, misses, duplicates, bad positions and a raw write.
    queue_cmd(ACT_FIND, 32'h0, 32'h0, 8'd0, 1'b0);
    queue_cmd(ACT_GET_POS, 32'h0, 32'h0, 8'd0, 1'b0);
    queue_cmd(ACT_REMOVE_KEY, 32'h5, 32'h0, 8'd0, 1'b0);
    queue_cmd(ACT_ADD, 32'h8000_0000, 32'hFFFF_FFFF, 8'd0, 1'b0);
    queue_cmd(ACT_ADD, 32'hFFFF_FFFF, 32'h1234_5678, 8'd0, 1'b0);
    queue_cmd(ACT_ADD, 32'h0, 32'h0, 8'd0, 1'b0);
    queue_cmd(ACT_ADD, 32'hFFFF_FFFF, 32'h0, 8'd0, 1'b0);
    queue_cmd(ACT_FIND, 32'h8000_0000, 32'h0, 8'd0, 1'b0);
    queue_cmd(ACT_FIND, 32'h7FFF_FFFF, 32'h0, 8'd0, 1'b0);
    queue_cmd(ACT_FIND_OR_ADD, 32'h0, 32'hAAAA_AAAA, 8'd0, 1'b0);
    queue_cmd(ACT_FIND_OR_ADD, 32'h0000_0100, 32'h5555_5555, 8'd0, 1'b0);
    queue_cmd(ACT_REPLACE, 32'hFFFF_FFFF, 32'hDEAD_BEEF, 8'd0, 1'b0);
    queue_cmd(ACT_REPLACE, 32'h0000_0200, 32'h1, 8'd0, 1'b0);
    queue_cmd(ACT_REPLACE, 32'h0000_0200, 32'h2, 8'd0, 1'b1);
    queue_cmd(ACT_GET_POS, 32'h0, 32'h0, 8'd4, 1'b0);
    queue_cmd(ACT_GET_POS, 32'h0, 32'h0, 8'd255, 1'b0);
    queue_cmd(ACT_SET_POS, 32'h0, 32'h0, 8'd255, 1'b0);
    queue_cmd(ACT_SET_POS, 32'hFFFF_FFF0, 32'h7777_7777, 8'd1, 1'b0);
    queue_cmd(ACT_FIND, 32'hFFFF_FFF0, 32'h0, 8'd0, 1'b0);
    queue_cmd(ACT_REMOVE_POS, 32'h0, 32'h0, 8'd0, 1'b0);
    queue_cmd(ACT_REMOVE_POS, 32'h0, 32'h0, 8'd170, 1'b0);
    queue_cmd(ACT_REMOVE_KEY, 32'hFFFF_FFFF, 32'h0, 8'd0, 1'b0);

    // Empty the table and fill it to the brim in ascending key order, after
    // letting every result drain. The last adds and inserts must see full.
    queue_cmd(ACT_REMOVE_POS, 32'h0, 32'h0, 8'd0, 1'b0, 1);
    for (int i = 0; i < 8; i++) queue_cmd(ACT_REMOVE_POS, 32'h0, 32'h0, 8'd0, 1'b0);
    for (int i = 0; i < Depth; i++)
      queue_cmd(ACT_ADD, 32'h0100_0000 + i * 32'h0000_1003, $urandom, 8'd0, 1'b0);
    queue_cmd(ACT_ADD, 32'hFFFF_FFFF, 32'h0, 8'd0, 1'b0);
    queue_cmd(ACT_FIND_OR_ADD, 32'h0, 32'h9999_9999, 8'd0, 1'b0);
    queue_cmd(ACT_REPLACE, 32'h5, 32'h0, 8'd0, 1'b1);
    queue_cmd(ACT_GET_POS, 32'h0, 32'h0, 8'd255, 1'b0);
    for (int i = 0; i < 30; i++) queue_random_cmd();
    // Unload from the middle and the front so the long shifts get exercised.
    for (int i = 0; i < 120; i++)
      queue_cmd(ACT_REMOVE_POS, 32'h0, 32'h0, 8'($urandom_range(0, 100)), 1'b0);

    // Random mix of everything, with a drain pause in the middle.
    for (int i = 0; i < 710; i++) begin
      queue_random_cmd();
      if (i == 300) pending_cmds[$].drain = 1;
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    wait (pending_cmds.size() == 0 && !start_i && awaited_results.size() == 0);
    repeat (TailCycles) @(posedge clk_i);

    if (awaited_results.size() > 0) begin
      mismatches++;
      $display("tb: %0d results never arrived", awaited_results.size());
    end
    $display("tb: %0d command beats, %0d result beats, %0d full refusals, %0d mismatches",
             beats_sent, results_seen, full_hits, mismatches);
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/skvt_pkg.sv
hdl/skvt_ram.sv
hdl/sorted_key_value_table_top.sv
tb/tb.sv
